>>> hdl/iprp_pkg.sv
// ----------------------------------------------------------------------------
// iprp_pkg
// Shared types for the address range to prefix block splitter.
// ----------------------------------------------------------------------------
package iprp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ASC  = 3'b010,
    ST_DESC = 3'b100
  } state_t;

  typedef struct packed {
    logic hit;
    logic fits;
    logic last_blk;
    logic at_top;
  } step_t;

endpackage

>>> hdl/ip_range_to_prefix_blocks_core.sv
// ----------------------------------------------------------------------------
// ip_range_to_prefix_blocks_core
// Splits an address range into the shortest run of aligned prefix blocks.
//
//   channel  ports                                   handshake
//   input    in_start_address, in_host_count         start && !busy
//   result   out_block_base, out_prefix_len,         out_valid strobe,
//            out_last                                one cycle, no stall
//
// One bit position is scanned per cycle by the shared step unit: first
// upward through the cursor's alignment, then downward through the bits of
// the remaining count. A zero count never raises busy. Each block leaves
// on a registered strobe in the cycle after its scan step. Reset clears
// the sequencer. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module ip_range_to_prefix_blocks_core #(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_start_address,
  input  logic [31:0] in_host_count,
  output logic        out_valid,
  output logic [31:0] out_block_base,
  output logic [5:0]  out_prefix_len,
  output logic        out_last
);

  localparam int KW = $clog2(ADDR_BITS);
  localparam logic [KW-1:0] KTOP = KW'(ADDR_BITS - 1);

  iprp_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [ADDR_BITS-1:0] cursor_r, cursor_nxt;
  logic [ADDR_BITS-1:0] hosts_r, hosts_nxt;
  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] base_r;
  logic [5:0]           plen_r;
  logic                 last_r;

  iprp_pkg::step_t      ctl;
  logic [ADDR_BITS-1:0] cursor_sum;
  logic [ADDR_BITS-1:0] hosts_diff;
  logic                 emit;

  iprp_step #(
    .ADDR_BITS (ADDR_BITS),
    .KW        (KW)
  ) u_step (
    .desc       (state_r == iprp_pkg::ST_DESC),
    .k          (k_r),
    .cursor     (cursor_r),
    .hosts      (hosts_r),
    .ctl        (ctl),
    .cursor_sum (cursor_sum),
    .hosts_diff (hosts_diff)
  );

  assign busy = (state_r != iprp_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cursor_nxt = cursor_r;
    hosts_nxt  = hosts_r;
    emit       = 1'b0;
    unique case (state_r)
      iprp_pkg::ST_IDLE: begin
        if (start) begin
          cursor_nxt = in_start_address[ADDR_BITS-1:0];
          hosts_nxt  = in_host_count[ADDR_BITS-1:0];
          k_nxt      = '0;
          if (in_host_count[ADDR_BITS-1:0] != '0) begin
            state_nxt = iprp_pkg::ST_ASC;
          end
        end
      end
      iprp_pkg::ST_ASC: begin
        if (!ctl.fits) begin
          state_nxt = iprp_pkg::ST_DESC;
          k_nxt     = k_r - 1'b1;
        end else if (ctl.hit) begin
          emit       = 1'b1;
          cursor_nxt = cursor_sum;
          hosts_nxt  = hosts_diff;
          if (ctl.last_blk) begin
            state_nxt = iprp_pkg::ST_IDLE;
          end else if (ctl.at_top) begin
            state_nxt = iprp_pkg::ST_DESC;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else if (ctl.at_top) begin
          state_nxt = iprp_pkg::ST_DESC;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      iprp_pkg::ST_DESC: begin
        if (ctl.hit) begin
          emit       = 1'b1;
          cursor_nxt = cursor_sum;
          hosts_nxt  = hosts_diff;
          if (ctl.last_blk) begin
            state_nxt = iprp_pkg::ST_IDLE;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      default: begin
        state_nxt = iprp_pkg::ST_IDLE;
        k_nxt     = KTOP;
      end
    endcase
    valid_nxt = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iprp_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    cursor_r <= cursor_nxt;
    hosts_r  <= hosts_nxt;
    if (emit) begin
      base_r <= cursor_r;
      plen_r <= 6'(ADDR_BITS) - 6'(k_r);
      last_r <= ctl.last_blk;
    end
  end

  assign out_valid      = valid_r;
  assign out_block_base = 32'(base_r);
  assign out_prefix_len = plen_r;
  assign out_last       = last_r;

endmodule

>>> hdl/iprp_step.sv
// ----------------------------------------------------------------------------
// iprp_step
// Shared scan unit: tests one bit position of the cursor or the remaining
// count and forms the advanced cursor and reduced count for that block size.
// ----------------------------------------------------------------------------
module iprp_step #(
  parameter int ADDR_BITS = 32,
  parameter int KW        = $clog2(ADDR_BITS)
) (
  input  logic                 desc,
  input  logic [KW-1:0]        k,
  input  logic [ADDR_BITS-1:0] cursor,
  input  logic [ADDR_BITS-1:0] hosts,
  output iprp_pkg::step_t      ctl,
  output logic [ADDR_BITS-1:0] cursor_sum,
  output logic [ADDR_BITS-1:0] hosts_diff
);

  localparam logic [KW-1:0] KTOP = KW'(ADDR_BITS - 1);

  logic [ADDR_BITS-1:0] blk;

  assign blk        = {{(ADDR_BITS-1){1'b0}}, 1'b1} << k;
  assign cursor_sum = cursor + blk;
  assign hosts_diff = hosts - blk;

  always_comb begin
    ctl.fits     = (blk <= hosts);
    ctl.hit      = desc ? hosts[k] : (cursor[k] & ctl.fits);
    ctl.last_blk = ctl.hit & (hosts == blk);
    ctl.at_top   = (k == KTOP);
  end

endmodule
